@@ sv/qte_pkg.sv @@
// Package for the quaternion to Euler angle core: widths, angle table, constants.
// Used by every module of the block; depends on nothing.
`default_nettype none
package qte_pkg;
  localparam int DefStages = 16;
  localparam int AngLen = 24;
  localparam int VW = 36;            // vector width: sums reach 2^32, then the gain of 1.65
  localparam int ZW = 34;            // Q30 angle accumulator
  localparam int SQW = 29;           // saturated sine magnitude width
  localparam int RW = 29;            // root result width

  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [ZW-1:0] ang_t;

  localparam ang_t PiQ30 = 34'sd3373259426;
  localparam vec_t OneQ28 = vec_t'(64'sd268435456);

  typedef struct packed {
    vec_t x;
    vec_t y;
    ang_t z;
  } cvec_t;

  function automatic ang_t atan_q30(input int i);
    case (i)
      0: atan_q30 = 34'sd843314857;
      1: atan_q30 = 34'sd497837829;
      2: atan_q30 = 34'sd263043837;
      3: atan_q30 = 34'sd133525159;
      4: atan_q30 = 34'sd67021687;
      5: atan_q30 = 34'sd33543516;
      6: atan_q30 = 34'sd16775851;
      7: atan_q30 = 34'sd8388437;
      8: atan_q30 = 34'sd4194283;
      9: atan_q30 = 34'sd2097149;
      default: atan_q30 = ang_t'(34'sd1048576 >>> (i - 10));
    endcase
  endfunction
endpackage
`default_nettype wire

@@ sv/qte_rot_cell.sv @@
// One vectoring CORDIC stage for three parallel angle lanes, registered.
// Depends on qte_pkg.
`default_nettype none
module qte_rot_cell #(
  parameter int Idx = 0
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire qte_pkg::cvec_t  din [3],
  output qte_pkg::cvec_t       dout [3]
);
  import qte_pkg::*;
  localparam ang_t Ang = atan_q30(Idx);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        if (!din[l].y[VW-1]) begin
          dout[l].x <= din[l].x + (din[l].y >>> Idx);
          dout[l].y <= din[l].y - (din[l].x >>> Idx);
          dout[l].z <= din[l].z + Ang;
        end else begin
          dout[l].x <= din[l].x - (din[l].y >>> Idx);
          dout[l].y <= din[l].y + (din[l].x >>> Idx);
          dout[l].z <= din[l].z - Ang;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/qte_sqrt_cell.sv @@
// One bit step of a restoring square root, registered, carrying side payload.
// Depends on qte_pkg.
`default_nettype none
module qte_sqrt_cell #(
  parameter int Bit = 0,
  parameter int PW = 1
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [57:0]   rem_in,
  input  wire logic [28:0]   root_in,
  input  wire logic [PW-1:0] pay_in,
  output logic [57:0]        rem_out,
  output logic [28:0]        root_out,
  output logic [PW-1:0]      pay_out
);
  import qte_pkg::*;
  logic [58:0] trial;
  always_comb begin
    trial = ({30'd0, root_in} << (Bit + 1)) | (59'd1 << (2 * Bit));
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pay_out <= pay_in;
      if ({1'b0, rem_in} >= trial) begin
        rem_out  <= rem_in - trial[57:0];
        root_out <= root_in | (29'd1 << Bit);
      end else begin
        rem_out  <= rem_in;
        root_out <= root_in;
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/quaternion_to_euler_angles_core.sv @@
// Top level of the quaternion to roll/pitch/yaw core: products, square root chain,
// CORDIC chain and output register. Depends on qte_pkg, qte_sqrt_cell, qte_rot_cell.
//
//   channel | signals                                           | dir
//   input   | in_valid, in_ready, q_w, q_x, q_y, q_z            | in
//   output  | out_valid, out_ready, roll_angle, pitch_angle,    | out
//           | yaw_angle, pitch_clipped                          |
//
// From acceptance to result an item passes three stages of products and square,
// 29 root cells, a pre-rotation stage, one cell per CORDIC stage (at most 24) and
// a rounding stage. One item is accepted per cycle while the output is not stalled.
// A stall on the output freezes the whole chain of cells; reset clears only the valid bits.
`default_nettype none
module quaternion_to_euler_angles_core #(
  parameter int CORDIC_STAGES = qte_pkg::DefStages
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] q_w,
  input  wire logic signed [15:0] q_x,
  input  wire logic signed [15:0] q_y,
  input  wire logic signed [15:0] q_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      roll_angle,
  output logic signed [14:0]      pitch_angle,
  output logic signed [15:0]      yaw_angle,
  output logic                    pitch_clipped
);
  import qte_pkg::*;
  localparam int NS = (CORDIC_STAGES > AngLen) ? AngLen : CORDIC_STAGES;
  localparam int NSQ = 29;
  localparam int DEPTH = 3 + NSQ + 1 + NS + 1;
  localparam int PW = 4 * VW + 2;

  // Stalls are handled by freezing every stage: the chain advances when the
  // output register is free or being emptied.
  logic adv;
  logic [DEPTH-1:0] vld;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage 1: the nine products.
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_wx <= q_w * q_x; p_yz <= q_y * q_z; p_xx <= q_x * q_x;
      p_yy <= q_y * q_y; p_wz <= q_w * q_z; p_xy <= q_x * q_y;
      p_zz <= q_z * q_z; p_wy <= q_w * q_y; p_zx <= q_z * q_x;
    end
  end

  // Stage 2: sums, saturation of the sine and its square.
  vec_t ry, rx, yy, yx, s_raw, s_sat;
  logic clip;
  always_comb begin
    ry = (vec_t'(p_wx) + vec_t'(p_yz)) <<< 1;
    rx = OneQ28 - ((vec_t'(p_xx) + vec_t'(p_yy)) <<< 1);
    yy = (vec_t'(p_wz) + vec_t'(p_xy)) <<< 1;
    yx = OneQ28 - ((vec_t'(p_yy) + vec_t'(p_zz)) <<< 1);
    s_raw = (vec_t'(p_wy) - vec_t'(p_zx)) <<< 1;
    clip = (s_raw > OneQ28) || (s_raw < -OneQ28);
    s_sat = (s_raw > OneQ28) ? OneQ28 : ((s_raw < -OneQ28) ? -OneQ28 : s_raw);
  end

  // The square is split into a 14x29 and a 15x29 partial product, summed in the next stage.
  logic [28:0] s_mag;
  logic [PW-1:0] pay2;
  logic [43:0] sq_lo, sq_hi;
  assign s_mag = s_sat[VW-1] ? 29'(-s_sat) : 29'(s_sat);
  always_ff @(posedge clk) begin
    if (adv) begin
      pay2  <= {clip, 1'b0, ry, rx, yy, yx};
      sq_lo <= 44'(s_mag[13:0]) * 44'(s_mag);
      sq_hi <= 44'(s_mag[28:14]) * 44'(s_mag);
    end
  end
  vec_t s2;
  logic [57:0] rem0;
  logic [PW-1:0] pay3;
  always_ff @(posedge clk) begin
    if (adv) begin
      rem0 <= 58'd72057594037927936 - (58'(sq_lo) + (58'(sq_hi) << 14));
      pay3 <= pay2;
    end
  end
  // The sine is delayed separately and rides in the low slot of the root chain's payload.
  logic [PW+VW-1:0] sp [NSQ+1];
  logic [57:0] srem [NSQ+1];
  logic [28:0] sroot [NSQ+1];
  vec_t s_d1, s_d;
  always_ff @(posedge clk) begin
    if (adv) begin
      s_d1 <= s_sat;
      s_d  <= s_d1;
    end
  end
  assign s2 = s_d;
  assign sp[0] = {pay3, s2};
  assign srem[0] = rem0;
  assign sroot[0] = '0;

  // Cells hold while the chain is frozen.
  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    qte_sqrt_cell #(.Bit(NSQ - 1 - k), .PW(PW + VW)) u_cell (
      .clk(clk), .en(adv), .rem_in(srem[k]), .root_in(sroot[k]), .pay_in(sp[k]),
      .rem_out(srem[k+1]), .root_out(sroot[k+1]), .pay_out(sp[k+1])
    );
  end

  // Pre-rotation into the right half plane.
  cvec_t pre [3];
  logic [2:0] zero_pre;
  logic clip_pre;
  vec_t in_y [3], in_x [3];
  always_comb begin
    in_y[0] = sp[NSQ][VW + 4*VW - 1 -: VW];     // ry
    in_x[0] = sp[NSQ][VW + 3*VW - 1 -: VW];     // rx
    in_y[2] = sp[NSQ][VW + 2*VW - 1 -: VW];     // yy
    in_x[2] = sp[NSQ][VW + VW - 1 -: VW];       // yx
    in_y[1] = sp[NSQ][VW-1:0];                  // sine
    in_x[1] = vec_t'(sroot[NSQ]);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      clip_pre <= sp[NSQ][PW+VW-1];
      for (int l = 0; l < 3; l++) begin
        zero_pre[l] <= (in_x[l] == '0) && (in_y[l] == '0);
        if (in_x[l][VW-1]) begin
          pre[l].x <= -in_x[l];
          pre[l].y <= -in_y[l];
          pre[l].z <= in_y[l][VW-1] ? -PiQ30 : PiQ30;
        end else begin
          pre[l].x <= in_x[l];
          pre[l].y <= in_y[l];
          pre[l].z <= '0;
        end
      end
    end
  end

  cvec_t cc [NS+1][3];
  logic [3:0] side [NS];
  assign cc[0] = pre;
  for (genvar i = 0; i < NS; i++) begin : g_rot
    qte_rot_cell #(.Idx(i)) u_cell (.clk(clk), .en(adv), .din(cc[i]), .dout(cc[i+1]));
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= {clip_pre, zero_pre};
      for (int i = 1; i < NS; i++) side[i] <= side[i-1];
    end
  end

  // Rounding to Q13, zero for a zero vector, and limiting.
  function automatic logic signed [16:0] rnd(input ang_t z, input logic zr,
                                             input logic signed [16:0] lim);
    ang_t t;
    logic signed [16:0] r;
    t = (z + ang_t'(34'sd65536)) >>> 17;
    r = 17'(t);
    if (zr) r = '0;
    else if (r > lim) r = lim;
    else if (r < -lim) r = -lim;
    return r;
  endfunction

  logic signed [16:0] r0, r1, r2;
  always_comb begin
    r0 = rnd(cc[NS][0].z, side[NS-1][0], 17'sd25736);
    r1 = rnd(cc[NS][1].z, side[NS-1][1], 17'sd12868);
    r2 = rnd(cc[NS][2].z, side[NS-1][2], 17'sd25736);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      roll_angle <= r0[15:0];
      pitch_angle <= r1[14:0];
      yaw_angle <= r2[15:0];
      pitch_clipped <= side[NS-1][3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end
  assign out_valid = vld[DEPTH-1];
endmodule
`default_nettype wire

@@ tb/tb_quaternion_to_euler_angles_core.sv @@
// Testbench for quaternion_to_euler_angles_core: random and directed quaternions,
// predicted by a local fixed-point model of the CORDIC angle math. Depends on quaternion_to_euler_angles_core.
`timescale 1ns / 100ps
module tb_quaternion_to_euler_angles_core;
  localparam int Stages = 16;
  localparam int Latency = Stages + 34;
  localparam longint MaxCycles = 400000;
  localparam longint OneFix = 64'sd268435456;
  localparam longint PiFix = 64'sd3373259426;
  localparam int PiOut = 25736;
  localparam int HalfPiOut = 12868;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               clip;
  } euler_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] q_w = '0, q_x = '0, q_y = '0, q_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] roll_angle, yaw_angle;
  logic signed [14:0] pitch_angle;
  logic pitch_clipped;

  quat_t  quat_queue[$];
  euler_t angle_queue[$];
  int     send_idle_pct = 17;
  int     recv_idle_pct = 86;
  int     errors = 0;
  longint cycles = 0;
  logic   stim_done = 1'b0;
  logic   in_taken = 1'b0;

  quaternion_to_euler_angles_core #(.CORDIC_STAGES(Stages)) uut (
    .clk, .rst, .in_valid, .in_ready, .q_w, .q_x, .q_y, .q_z,
    .out_valid, .out_ready, .roll_angle, .pitch_angle, .yaw_angle, .pitch_clipped
  );

  always #5 clk = ~clk;

  function automatic longint atan_fix(input int i);
    case (i)
      0: return 843314857;
      1: return 497837829;
      2: return 263043837;
      3: return 133525159;
      4: return 67021687;
      5: return 33543516;
      6: return 16775851;
      7: return 8388437;
      8: return 4194283;
      9: return 2097149;
      default: return 64'sd1048576 >>> (i - 10);
    endcase
  endfunction

  function automatic longint vector_angle(input longint vy, input longint vx);
    longint a, xs, ys;
    a = 0;
    if (vx == 0 && vy == 0) return 0;
    if (vx < 0) begin
      a = (vy >= 0) ? PiFix : -PiFix;
      vx = -vx;
      vy = -vy;
    end
    for (int i = 0; i < Stages && i < 24; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy >= 0) begin
        vx = vx + ys;
        vy = vy - xs;
        a += atan_fix(i);
      end else begin
        vx = vx - ys;
        vy = vy + xs;
        a -= atan_fix(i);
      end
    end
    return a;
  endfunction

  function automatic longint round_angle(input longint a, input longint lim);
    longint r;
    r = (a + 64'sd65536) >>> 17;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint floor_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic euler_t predict_angles(input quat_t q);
    longint w, x, y, z, s, c;
    euler_t e;
    w = q.w; x = q.x; y = q.y; z = q.z;
    s = 2 * (w * y - z * x);
    e.clip = 1'b0;
    if (s > OneFix) begin s = OneFix; e.clip = 1'b1; end
    if (s < -OneFix) begin s = -OneFix; e.clip = 1'b1; end
    c = floor_sqrt(longint'(OneFix * OneFix - s * s));
    e.roll = 16'(round_angle(vector_angle(2 * (w * x + y * z),
                                          OneFix - 2 * (x * x + y * y)), PiOut));
    e.pitch = 15'(round_angle(vector_angle(s, c), HalfPiOut));
    e.yaw = 16'(round_angle(vector_angle(2 * (w * z + x * y),
                                         OneFix - 2 * (y * y + z * z)), PiOut));
    return e;
  endfunction

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);  // whole field range, beyond the nominal one too
      1: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      2: return 16'($signed($urandom_range(0, 200)) - 100);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // Mostly unit quaternions, so the angles sweep the full circle.
  function automatic quat_t rand_quat();
    quat_t q;
    real a, n, vx, vy, vz;
    if ($urandom_range(0, 3) == 0) begin
      q = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
    end else begin
      vx = $itor($signed($urandom_range(0, 2000)) - 1000);
      vy = $itor($signed($urandom_range(0, 2000)) - 1000);
      vz = $itor($signed($urandom_range(0, 2000)) - 1000);
      a = $itor($signed($urandom_range(0, 2000)) - 1000);
      n = $sqrt(a * a + vx * vx + vy * vy + vz * vz) + 1.0e-9;
      q.w = 16'($rtoi(16384.0 * a / n));
      q.x = 16'($rtoi(16384.0 * vx / n));
      q.y = 16'($rtoi(16384.0 * vy / n));
      q.z = 16'($rtoi(16384.0 * vz / n));
    end
    return q;
  endfunction

  initial begin
    quat_t q;
    // Identity, gimbal lock both ways, zero quaternion, extremes of the fields.
    quat_queue.push_back('{16384, 0, 0, 0});
    quat_queue.push_back('{0, 0, 0, 0});
    quat_queue.push_back('{11585, 0, 11585, 0});
    quat_queue.push_back('{11585, 0, -11585, 0});
    quat_queue.push_back('{11585, 11585, 11585, 11585});
    quat_queue.push_back('{16384, 16384, 16384, -16384});
    quat_queue.push_back('{-16384, -16384, -16384, -16384});
    quat_queue.push_back('{16384, 16384, -16384, 16384});
    quat_queue.push_back('{32767, 32767, 32767, 32767});
    quat_queue.push_back('{-32768, -32768, -32768, -32768});
    quat_queue.push_back('{32767, -32768, 32767, -32768});
    quat_queue.push_back('{0, 16384, 0, 0});
    quat_queue.push_back('{0, 0, 0, 16384});
    quat_queue.push_back('{0, 0, 16384, 0});
    quat_queue.push_back('{0, 11585, 0, 11585});
    quat_queue.push_back('{-1, 16384, 1, -16384});
    quat_queue.push_back('{16383, 1, -1, 0});
    for (int i = 0; i < 750; i++) begin
      q = rand_quat();
      quat_queue.push_back(q);
      if (i == 250) begin
        wait (quat_queue.size() <= 1);
        send_idle_pct = 86;
        recv_idle_pct = 17;
      end else if (i == 500) begin
        wait (quat_queue.size() <= 1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end
    stim_done = 1'b1;
  end

  // Driver: inputs change on the falling edge. The item at the head of the queue
  // is the one on the ports until it has been taken.
  always @(negedge clk) begin
    if (cycles == 10) rst <= 1'b0;
    if (!rst) begin
      if (in_taken) void'(quat_queue.pop_front());
      if (!in_valid || in_taken) begin
        if (quat_queue.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
          in_valid <= 1'b1;
          {q_w, q_x, q_y, q_z} <= quat_queue[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(1, 100) > recv_idle_pct);
    end
  end

  // Monitor: prediction on acceptance, comparison on each result.
  always @(posedge clk) begin
    euler_t e;
    cycles <= cycles + 1;
    in_taken <= in_valid && in_ready && !rst;
    if (!rst) begin
      if (in_valid && in_ready)
        angle_queue.push_back(predict_angles({q_w, q_x, q_y, q_z}));
      if (out_valid && out_ready) begin
        if (angle_queue.size() == 0) begin
          $error("result with no quaternion outstanding");
          errors++;
        end else begin
          e = angle_queue.pop_front();
          if (roll_angle !== e.roll) begin
            $error("roll_angle expected %0d actual %0d", e.roll, roll_angle);
            errors++;
          end
          if (pitch_angle !== e.pitch) begin
            $error("pitch_angle expected %0d actual %0d", e.pitch, pitch_angle);
            errors++;
          end
          if (yaw_angle !== e.yaw) begin
            $error("yaw_angle expected %0d actual %0d", e.yaw, yaw_angle);
            errors++;
          end
          if (pitch_clipped !== e.clip) begin
            $error("pitch_clipped expected %0d actual %0d", e.clip, pitch_clipped);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    wait (stim_done && quat_queue.size() == 0 && !in_valid);
    wait (angle_queue.size() == 0);
    repeat (Latency + 10) @(posedge clk);
    if (errors == 0 && angle_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    wait (cycles >= MaxCycles);
    $display("simulation failed");
    $finish;
  end
endmodule

@@ quaternion_to_euler_angles_core.f @@
sv/qte_pkg.sv
sv/qte_rot_cell.sv
sv/qte_sqrt_cell.sv
sv/quaternion_to_euler_angles_core.sv
tb/tb_quaternion_to_euler_angles_core.sv
